// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the frame encoder.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the active-low reset is asserted.
`define GCFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define GCFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gcfe_pkg.sv =====
// Package for the gesture control frame encoder: frame layout, ASCII codes,
// register map, reset values and the throttle / hex helper functions. No dependencies.
`timescale 1ns / 1ps

package gcfe_pkg;

  localparam int FrameLen = 14;
  localparam int CntW     = $clog2(FrameLen);
  localparam int AddrW    = 4;
  localparam int DataW    = 32;
  localparam int DzW      = 15;
  localparam int CodeW    = 8;

  typedef logic [CntW-1:0] pos_t;

  // byte positions inside a frame
  localparam pos_t PosColon = pos_t'(0);
  localparam pos_t PosR     = pos_t'(1);
  localparam pos_t PosC     = pos_t'(2);
  localparam pos_t PosThrHi = pos_t'(3);
  localparam pos_t PosThrLo = pos_t'(4);
  localparam pos_t PosDirHi = pos_t'(7);
  localparam pos_t PosDirLo = pos_t'(8);
  localparam pos_t PosChkHi = pos_t'(11);
  localparam pos_t PosChkLo = pos_t'(12);
  localparam pos_t PosEnd   = pos_t'(FrameLen - 1);

  localparam logic [7:0] AsciiColon   = 8'h3A;
  localparam logic [7:0] AsciiR       = 8'h52;
  localparam logic [7:0] AsciiC       = 8'h43;
  localparam logic [7:0] AsciiZero    = 8'h30;
  localparam logic [7:0] AsciiSlash   = 8'h2F;
  localparam logic [7:0] HexNumBase   = 8'd48;
  localparam logic [7:0] HexAlphaBase = 8'd55;

  // bytes 1..10 that never change: 'R', 'C' and four '0'
  localparam logic [7:0] FixedSum =
    8'(int'(AsciiR) + int'(AsciiC) + 4 * int'(AsciiZero));

  localparam int ThrLinHi    = 30;
  localparam int ThrOffHi    = 60;
  localparam int ThrFracHi   = 70;
  localparam int ThrOffset   = 90;
  localparam int ThrFracBase = 150;
  localparam int ThrMax      = 160;

  typedef enum logic [1:0] {
    RegDeadZone  = 2'd0,
    RegRightCode = 2'd1,
    RegLeftCode  = 2'd2
  } reg_idx_t;

  localparam logic [DzW-1:0]   DeadZoneRst  = DzW'(20);
  localparam logic [CodeW-1:0] RightCodeRst = CodeW'(15);
  localparam logic [CodeW-1:0] LeftCodeRst  = CodeW'(143);

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? (8'(nib) + HexNumBase) : (8'(nib) + HexAlphaBase);
  endfunction

  // floor(4*d/5) as (4*d*13) >> 6, exact for d below 10
  function automatic logic [2:0] thr_frac(input logic [3:0] d);
    logic [8:0] p;
    p = 9'(d) * 9'd52;
    return p[8:6];
  endfunction

  function automatic logic [7:0] throttle(input logic [15:0] dy);
    logic [6:0] d;
    d = dy[6:0] - 7'(ThrOffHi);
    if (dy[15] || dy == 16'd0) begin
      return 8'd0;
    end else if (dy < 16'(ThrLinHi)) begin
      return {1'b0, dy[4:0], 2'b00};
    end else if (dy < 16'(ThrOffHi)) begin
      return 8'(dy[5:0]) + 8'(ThrOffset);
    end else if (dy < 16'(ThrFracHi)) begin
      return 8'(ThrFracBase) + 8'(thr_frac(d[3:0]));
    end else begin
      return 8'(ThrMax);
    end
  endfunction

endpackage

// ===== rtl/gesture_control_frame_encoder.sv =====
// Gesture control frame encoder. Accepts a delta_x / delta_y item, turns it into a
// 14-byte ASCII control frame ":RC<thr>00<dir>00<chk>/" and sends one byte per cycle.
// The byte serializer puts out one frame byte per clock. An item waits in the input
// register while the frame ahead of it is sent and moves to the serializer at the
// edge that puts that frame's closing '/' on the outputs; the next item is taken at
// that same edge. Frames therefore follow each other with no gap and start may be
// held high. On an idle block an accepted item moves from the input register to the
// serializer, and its first byte then passes through the output register. The
// receiver cannot stall: each byte is on out_frame_byte for exactly one cycle with
// out_valid high, and out_frame_end marks the closing '/'. busy is high while an
// item waits for the serializer. Registers: 0x0 dead zone, 0x4 right code, 0x8 left
// code; write them only while no frame is pending.
// Depends on gcfe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gesture_control_frame_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          in_delta_x,
  input  logic signed [15:0]          in_delta_y,
  output logic                        out_valid,
  output logic [7:0]                  out_frame_byte,
  output logic                        out_frame_end,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gcfe_pkg::AddrW-1:0]  paddr,
  input  logic [gcfe_pkg::DataW-1:0]  pwdata,
  output logic [gcfe_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  // configuration
  logic [gcfe_pkg::DzW-1:0]   cfg_dead_zone_r;
  logic [gcfe_pkg::CodeW-1:0] cfg_right_code_r;
  logic [gcfe_pkg::CodeW-1:0] cfg_left_code_r;
  gcfe_pkg::reg_idx_t         cfg_idx;
  logic                       cfg_wr;

  // input register
  logic                       in_vld_r;
  logic signed [15:0]         dx_r;
  logic signed [15:0]         dy_r;
  logic                       accept;
  logic                       load;

  // frame fields and serializer
  logic [7:0]                 thr_r, thr_nxt;
  logic [7:0]                 dir_r, dir_nxt;
  logic [7:0]                 chk_r, chk_nxt;
  logic                       act_r;
  gcfe_pkg::pos_t             cnt_r;
  logic                       last_pos;
  logic [7:0]                 byte_sel;

  logic signed [16:0]         dx_ext;
  logic signed [16:0]         dz_pos;
  logic signed [16:0]         dz_neg;
  logic [7:0]                 sum;

  // output register
  logic                       out_valid_r;
  logic [7:0]                 out_frame_byte_r;
  logic                       out_frame_end_r;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = gcfe_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dead_zone_r  <= gcfe_pkg::DeadZoneRst;
      cfg_right_code_r <= gcfe_pkg::RightCodeRst;
      cfg_left_code_r  <= gcfe_pkg::LeftCodeRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        gcfe_pkg::RegDeadZone:  cfg_dead_zone_r  <= pwdata[gcfe_pkg::DzW-1:0];
        gcfe_pkg::RegRightCode: cfg_right_code_r <= pwdata[gcfe_pkg::CodeW-1:0];
        gcfe_pkg::RegLeftCode:  cfg_left_code_r  <= pwdata[gcfe_pkg::CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      gcfe_pkg::RegDeadZone:  prdata = gcfe_pkg::DataW'(cfg_dead_zone_r);
      gcfe_pkg::RegRightCode: prdata = gcfe_pkg::DataW'(cfg_right_code_r);
      gcfe_pkg::RegLeftCode:  prdata = gcfe_pkg::DataW'(cfg_left_code_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------- input handshake ----------------
  assign last_pos = (cnt_r == gcfe_pkg::PosEnd);
  // hand the held item to the serializer when it is idle or on its last byte
  assign load     = in_vld_r && (!act_r || last_pos);
  assign busy     = in_vld_r && !load;
  assign accept   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r <= in_delta_x;
      dy_r <= in_delta_y;
    end
  end

  // ---------------- frame field computation ----------------
  always_comb begin
    dx_ext  = {dx_r[15], dx_r};
    dz_pos  = {2'b00, cfg_dead_zone_r};
    dz_neg  = -dz_pos;
    thr_nxt = gcfe_pkg::throttle(dy_r);
    if (dx_ext > dz_pos) begin
      dir_nxt = cfg_right_code_r;
    end else if (dx_ext < dz_neg) begin
      dir_nxt = cfg_left_code_r;
    end else begin
      dir_nxt = 8'd0;
    end
    sum = gcfe_pkg::FixedSum
        + gcfe_pkg::hex_digit(thr_nxt[7:4]) + gcfe_pkg::hex_digit(thr_nxt[3:0])
        + gcfe_pkg::hex_digit(dir_nxt[7:4]) + gcfe_pkg::hex_digit(dir_nxt[3:0]);
    chk_nxt = 8'd0 - sum;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      thr_r <= thr_nxt;
      dir_r <= dir_nxt;
      chk_r <= chk_nxt;
    end
  end

  // ---------------- serializer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (load) begin
      act_r <= 1'b1;
      cnt_r <= gcfe_pkg::PosColon;
    end else if (act_r) begin
      if (last_pos) begin
        act_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + gcfe_pkg::pos_t'(1);
      end
    end
  end

  always_comb begin
    unique case (cnt_r)
      gcfe_pkg::PosColon: byte_sel = gcfe_pkg::AsciiColon;
      gcfe_pkg::PosR:     byte_sel = gcfe_pkg::AsciiR;
      gcfe_pkg::PosC:     byte_sel = gcfe_pkg::AsciiC;
      gcfe_pkg::PosThrHi: byte_sel = gcfe_pkg::hex_digit(thr_r[7:4]);
      gcfe_pkg::PosThrLo: byte_sel = gcfe_pkg::hex_digit(thr_r[3:0]);
      gcfe_pkg::PosDirHi: byte_sel = gcfe_pkg::hex_digit(dir_r[7:4]);
      gcfe_pkg::PosDirLo: byte_sel = gcfe_pkg::hex_digit(dir_r[3:0]);
      gcfe_pkg::PosChkHi: byte_sel = gcfe_pkg::hex_digit(chk_r[7:4]);
      gcfe_pkg::PosChkLo: byte_sel = gcfe_pkg::hex_digit(chk_r[3:0]);
      gcfe_pkg::PosEnd:   byte_sel = gcfe_pkg::AsciiSlash;
      default:            byte_sel = gcfe_pkg::AsciiZero;  // "00" padding
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      out_frame_end_r <= 1'b0;
    end else begin
      out_valid_r     <= act_r;
      out_frame_end_r <= act_r && last_pos;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_byte_r <= byte_sel;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_frame_end  = out_frame_end_r;

  // ---------------- assertions ----------------
  `GCFE_ASSERT(a_end_has_valid, clk, rst_n, out_frame_end |-> out_valid,
               "frame end without valid")
  `GCFE_ASSERT(a_load_starts, clk, rst_n,
               load |=> (act_r && cnt_r == gcfe_pkg::PosColon),
               "serializer did not start a frame")
  `GCFE_ASSERT(a_frame_whole, clk, rst_n,
               out_frame_end |-> ($past(out_valid, 13) &&
                                  $past(out_frame_byte, 13) == gcfe_pkg::AsciiColon),
               "frame end without a full frame before it")
  `GCFE_ASSERT(a_accept_held, clk, rst_n, accept |=> in_vld_r, "accepted item not held")

endmodule

// ===== test/gesture_control_frame_encoder_tb.sv =====
// Testbench for gesture_control_frame_encoder: directed gesture table, then random
// bursts over several register settings, each frame byte checked against a local model.
// Depends on gcfe_pkg (register indexes, port widths) and the RTL.
`timescale 1ns / 1ps

module gesture_control_frame_encoder_tb;

  localparam int FrameBytes    = 14;
  localparam int ItemsPerPhase = 40;
  localparam int RandomPhases  = 7;
  localparam int LimitCycles   = 200000;
  localparam int ReportMax     = 10;

  // index past the register map; writes to it must be dropped
  localparam logic [1:0] RegUnmapped = 2'd3;

  localparam logic [7:0] ChColon = ":";
  localparam logic [7:0] ChR     = "R";
  localparam logic [7:0] ChC     = "C";
  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChSlash = "/";

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               known;  // thr/dir below are typed in, not predicted
    logic [7:0]         thr;
    logic [7:0]         dir;
  } gesture_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } frame_char_t;

  // directed part, reset register values (dead zone 20, right 15, left 143)
  localparam int NumRows = 18;
  localparam gesture_row_t GestureRows [NumRows] = '{
    '{16'sd0,      16'sd0,      1'b1, 8'd0,   8'd0},
    '{16'sh8000,   16'sh8000,   1'b1, 8'd0,   8'd143},
    '{16'sd32767,  16'sd32767,  1'b1, 8'd160, 8'd15},
    '{16'sd21,     16'sd1,      1'b0, 8'd0,   8'd0},
    '{16'sd20,     16'sd29,     1'b0, 8'd0,   8'd0},
    '{-16'sd20,    16'sd30,     1'b0, 8'd0,   8'd0},
    '{-16'sd21,    16'sd59,     1'b0, 8'd0,   8'd0},
    '{16'sd0,      16'sd60,     1'b0, 8'd0,   8'd0},
    '{16'sd0,      16'sd64,     1'b0, 8'd0,   8'd0},
    '{16'sd0,      16'sd69,     1'b0, 8'd0,   8'd0},
    '{16'sd0,      16'sd70,     1'b1, 8'd160, 8'd0},
    '{16'sd0,      -16'sd1,     1'b1, 8'd0,   8'd0},
    '{-16'sd1,     16'sd31,     1'b0, 8'd0,   8'd0},
    '{16'sd100,    16'sd45,     1'b0, 8'd0,   8'd0},
    '{-16'sd100,   16'sd65,     1'b0, 8'd0,   8'd0},
    '{16'sd1,      16'sd2,      1'b0, 8'd0,   8'd0},
    '{16'sh5555,   16'sh1234,   1'b0, 8'd0,   8'd0},
    '{16'shAAAA,   16'shAAAA,   1'b0, 8'd0,   8'd0}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic signed [15:0]           in_delta_x;
  logic signed [15:0]           in_delta_y;
  logic                         out_valid;
  logic [7:0]                   out_frame_byte;
  logic                         out_frame_end;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [gcfe_pkg::AddrW-1:0]   paddr;
  logic [gcfe_pkg::DataW-1:0]   pwdata;
  logic [gcfe_pkg::DataW-1:0]   prdata;
  logic                         pready;

  // local copy of the register file
  logic [14:0] dead_zone_q;
  logic [7:0]  right_code_q;
  logic [7:0]  left_code_q;

  frame_char_t pending_chars[$];
  int          mismatches;
  int          cycle_count;

  gesture_control_frame_encoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_delta_x     (in_delta_x),
    .in_delta_y     (in_delta_y),
    .out_valid      (out_valid),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'd48 + 8'(nib) : 8'd55 + 8'(nib);
  endfunction

  function automatic logic [7:0] throttle_code(input logic signed [15:0] dy);
    int v;
    v = dy;
    if (v <= 0) return 8'd0;
    if (v < 30) return 8'(4 * v);
    if (v < 60) return 8'(v + 90);
    if (v < 70) return 8'(150 + ((v - 60) * 4) / 5);
    return 8'd160;
  endfunction

  function automatic logic [7:0] steer_code(input logic signed [15:0] dx);
    int v;
    int dz;
    v  = dx;
    dz = int'(dead_zone_q);
    if (v > dz) return right_code_q;
    if (v < -dz) return left_code_q;
    return 8'd0;
  endfunction

  task automatic queue_frame(input logic [7:0] thr, input logic [7:0] dir);
    logic [7:0]  fr [FrameBytes];
    int          sum;
    logic [7:0]  chk;
    frame_char_t fc;
    fr[0]  = ChColon;
    fr[1]  = ChR;
    fr[2]  = ChC;
    fr[3]  = hex_char(thr[7:4]);
    fr[4]  = hex_char(thr[3:0]);
    fr[5]  = ChZero;
    fr[6]  = ChZero;
    fr[7]  = hex_char(dir[7:4]);
    fr[8]  = hex_char(dir[3:0]);
    fr[9]  = ChZero;
    fr[10] = ChZero;
    sum = 0;
    for (int i = 1; i <= 10; i++) sum += fr[i];
    chk = 8'(-sum);
    fr[11] = hex_char(chk[7:4]);
    fr[12] = hex_char(chk[3:0]);
    fr[13] = ChSlash;
    for (int i = 0; i < FrameBytes; i++) begin
      fc.ch   = fr[i];
      fc.last = (i == FrameBytes - 1);
      pending_chars.push_back(fc);
    end
  endtask

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= ReportMax) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      gcfe_pkg::RegDeadZone:  dead_zone_q  = data[14:0];
      gcfe_pkg::RegRightCode: right_code_q = data[7:0];
      gcfe_pkg::RegLeftCode:  left_code_q  = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // holds start until the item is taken at a rising edge with busy low
  task automatic send_gesture(input logic signed [15:0] dx, input logic signed [15:0] dy);
    @(negedge clk);
    start      <= 1'b1;
    in_delta_x <= dx;
    in_delta_y <= dy;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic settle();
    pause_sender(1);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_chars
    frame_char_t want;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected byte %h end %b", out_frame_byte, out_frame_end));
      end else begin
        want = pending_chars.pop_front();
        if (out_frame_byte !== want.ch || out_frame_end !== want.last) begin
          report($sformatf("byte exp %h end %b, got %h end %b",
                           want.ch, want.last, out_frame_byte, out_frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int                 left;
    int                 burst;
    int                 dzi;
    int                 off;
    bit                 gappy;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    gesture_row_t       row;

    mismatches   = 0;
    cycle_count  = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_delta_x   = '0;
    in_delta_y   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    dead_zone_q  = gcfe_pkg::DeadZoneRst;
    right_code_q = gcfe_pkg::RightCodeRst;
    left_code_q  = gcfe_pkg::LeftCodeRst;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      row = GestureRows[r];
      send_gesture(row.dx, row.dy);
      if (row.known) begin
        queue_frame(row.thr, row.dir);
      end else begin
        queue_frame(throttle_code(row.dy), steer_code(row.dx));
      end
      if (r % 5 == 4) pause_sender($urandom_range(1, 3));
    end
    settle();

    for (int p = 1; p <= RandomPhases; p++) begin
      case (p)
        1: begin
          write_reg(gcfe_pkg::RegDeadZone,  32'd0);
          write_reg(gcfe_pkg::RegRightCode, 32'hFF);
          write_reg(gcfe_pkg::RegLeftCode,  32'h00);
        end
        2: begin
          write_reg(gcfe_pkg::RegDeadZone,  32'h7FFF);
          write_reg(gcfe_pkg::RegRightCode, 32'h00);
          write_reg(gcfe_pkg::RegLeftCode,  32'hFF);
        end
        default: begin
          // upper bits are don't-care; keep the dead zone small so both codes show up
          write_reg(gcfe_pkg::RegDeadZone,
                    {17'($urandom), 15'($urandom_range(0, 300))});
          write_reg(gcfe_pkg::RegRightCode, $urandom);
          write_reg(gcfe_pkg::RegLeftCode,  $urandom);
          if (p == 3) write_reg(RegUnmapped, $urandom);
        end
      endcase

      gappy = (p % 3 != 0);
      left  = ItemsPerPhase;
      while (left > 0) begin
        burst = $urandom_range(1, 10);
        for (int k = 0; k < burst && left > 0; k++) begin
          dzi = int'(dead_zone_q);
          if ($urandom_range(0, 3) == 0) begin
            dx = 16'($urandom);
            dy = 16'($urandom);
          end else begin
            off = $urandom_range(0, 4) - 2;
            dx  = $urandom_range(0, 1) ? 16'(dzi + off) : 16'(-dzi - off);
            dy  = 16'($urandom_range(0, 85) - 5);
          end
          send_gesture(dx, dy);
          queue_frame(throttle_code(dy), steer_code(dx));
          left--;
        end
        if (gappy) pause_sender($urandom_range(1, 5));
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
